[hw/rtl/sewt_pkg.sv]
// ----------------------------------------------------------------------------
// sewt_pkg
// Shared types, constants and helpers of the symmetric edge weight table.
// ----------------------------------------------------------------------------
package sewt_pkg;

  // sizing
  localparam int MAX_POINTS  = 64;
  localparam int WEIGHT_BITS = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int DIST_W      = 32;
  localparam int LIVE_MAX    = (MAX_POINTS < 64) ? MAX_POINTS : 64;
  localparam int PAIR_DEPTH  = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int SLOT_W      = $clog2(PAIR_DEPTH);
  localparam int PROD_W      = SLOT_W + 1;
  localparam int WORD_W      = WEIGHT_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_LIST  = 2'd2;
  localparam logic [1:0] REQ_SKIP  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_CHECK,
    CMD_REPLY,
    CMD_LIST
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CHECK,
    BK_LIST
  } back_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [DIST_W-1:0] new_distance;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DIST_W-1:0] found_distance;
    logic [IDX_W-1:0]  neighbor_index;
    logic              last;
  } rsp_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [SLOT_W-1:0]      slot;
    logic [WEIGHT_BITS-1:0] weight;
    logic [1:0]             status;
    logic [IDX_W-1:0]       point;
    logic [CNT_W-1:0]       count;
  } cmd_t;

  // queue handshake seen by the back end
  typedef struct packed {
    logic empty;
    cmd_t head;
  } queue_out_t;

  // point count limited to what the store and index fields reach
  function automatic logic [CNT_W-1:0] live_count(input logic [CNT_W-1:0] pc);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(LIVE_MAX);
    return (pc > lim) ? lim : pc;
  endfunction

  // slot of the pair (lo, hi), lo < hi; the product is always even
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(lo) * (PROD_W'(2 * MAX_POINTS - 1) - PROD_W'(lo));
    return SLOT_W'(prod >> 1) + SLOT_W'(hi) - SLOT_W'(lo) - SLOT_W'(1);
  endfunction

endpackage

[hw/rtl/symmetric_edge_weight_table.sv]
// Path: a ready-made reply passes the queue entry and output register, a check word also
// the store read register; a listing holds each hit back until the next hit or scan end.
// Throughput: adds and ready-made replies one per cycle while the back end is idle and the
// output free; checks and listings hold the back end, set by the store's single read port.
// Reset: a clearing pass sweeps the valid flags of all 2016 slots, no request taken.
// ----------------------------------------------------------------------------
// symmetric_edge_weight_table
// Undirected edge weight store with add, check and neighbour listing requests.
// ----------------------------------------------------------------------------
module symmetric_edge_weight_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sewt_pkg::req_t             in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sewt_pkg::rsp_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sewt_pkg::CNT_W-1:0] cfg_data
);

  logic [sewt_pkg::CNT_W-1:0] point_count_r;
  logic [sewt_pkg::CNT_W-1:0] point_count_nxt;
  logic                       clearing;
  logic                       queue_full;
  logic                       push;
  logic                       pop;
  sewt_pkg::cmd_t             cmd;
  sewt_pkg::queue_out_t       q_out;

  // point count register
  assign cfg_ready       = 1'b1;
  assign point_count_nxt = (cfg_valid && cfg_ready) ? cfg_data : point_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else begin
      point_count_r <= point_count_nxt;
    end
  end

  // request classification
  sewt_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .point_count (point_count_r),
    .clearing    (clearing),
    .queue_full  (queue_full),
    .push        (push),
    .cmd         (cmd)
  );

  // command queue
  sewt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .full   (queue_full),
    .q_out  (q_out)
  );

  // execution and result word
  sewt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_out     (q_out),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/sewt_ram.sv]
// ----------------------------------------------------------------------------
// sewt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sewt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/sewt_front.sv]
// ----------------------------------------------------------------------------
// sewt_front
// Request front end: range checks, pair ordering and slot calculation.
// ----------------------------------------------------------------------------
module sewt_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sewt_pkg::req_t                in_data,
  input  logic [sewt_pkg::CNT_W-1:0]    point_count,
  input  logic                          clearing,
  input  logic                          queue_full,
  output logic                          push,
  output sewt_pkg::cmd_t                cmd
);

  logic [sewt_pkg::CNT_W-1:0] live;
  logic [sewt_pkg::IDX_W-1:0] a_idx;
  logic [sewt_pkg::IDX_W-1:0] b_idx;
  logic [sewt_pkg::IDX_W-1:0] lo_idx;
  logic [sewt_pkg::IDX_W-1:0] hi_idx;
  logic                       a_oor;
  logic                       b_oor;
  logic                       keep;

  assign live   = sewt_pkg::live_count(point_count);
  assign a_idx  = in_data.first_index;
  assign b_idx  = in_data.second_index;
  assign a_oor  = sewt_pkg::CNT_W'(a_idx) >= live;
  assign b_oor  = sewt_pkg::CNT_W'(b_idx) >= live;
  assign lo_idx = (a_idx < b_idx) ? a_idx : b_idx;
  assign hi_idx = (a_idx < b_idx) ? b_idx : a_idx;

  // no word taken during the clearing pass or with the queue full
  assign in_stall = clearing | queue_full;
  assign push     = in_valid & ~in_stall & keep;

  // classify the word into a back-end command
  always_comb begin
    keep       = 1'b1;
    cmd.kind   = sewt_pkg::CMD_REPLY;
    cmd.slot   = sewt_pkg::slot_of(lo_idx, hi_idx);
    cmd.weight = sewt_pkg::WEIGHT_BITS'(in_data.new_distance);
    cmd.status = sewt_pkg::STAT_OK;
    cmd.point  = a_idx;
    cmd.count  = live;
    unique case (in_data.req_type)
      sewt_pkg::REQ_ADD, sewt_pkg::REQ_CHECK: begin
        if (a_oor || b_oor) begin
          cmd.status = sewt_pkg::STAT_RANGE;
        end else if (a_idx == b_idx) begin
          // self pair: add dropped, check answers ok with zero
          keep = (in_data.req_type == sewt_pkg::REQ_CHECK);
        end else if (in_data.req_type == sewt_pkg::REQ_ADD) begin
          cmd.kind = sewt_pkg::CMD_WRITE;
        end else begin
          cmd.kind = sewt_pkg::CMD_CHECK;
        end
      end
      sewt_pkg::REQ_LIST: begin
        if (a_oor) begin
          cmd.status = sewt_pkg::STAT_RANGE;
        end else begin
          cmd.kind = sewt_pkg::CMD_LIST;
        end
      end
      sewt_pkg::REQ_SKIP: begin
        keep = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/sewt_queue.sv]
// ----------------------------------------------------------------------------
// sewt_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sewt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sewt_pkg::cmd_t       cmd_in,
  input  logic                 pop,
  output logic                 full,
  output sewt_pkg::queue_out_t q_out
);

  sewt_pkg::cmd_t                entry_r [sewt_pkg::QUEUE_DEPTH];
  logic [sewt_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [sewt_pkg::QUEUE_AW-1:0] wr_ptr_nxt;
  logic [sewt_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [sewt_pkg::QUEUE_AW-1:0] rd_ptr_nxt;
  logic [sewt_pkg::QUEUE_AW:0]   count_r;
  logic [sewt_pkg::QUEUE_AW:0]   count_nxt;
  logic                          empty;

  assign empty      = (count_r == '0);
  assign full       = (count_r == (sewt_pkg::QUEUE_AW + 1)'(sewt_pkg::QUEUE_DEPTH));
  assign q_out.empty = empty;
  assign q_out.head  = entry_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  // queue never overrun or underrun
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");

endmodule

[hw/rtl/sewt_back.sv]
// ----------------------------------------------------------------------------
// sewt_back
// Command back end: edge store, clearing pass, checks and neighbour scan.
// ----------------------------------------------------------------------------
module sewt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sewt_pkg::queue_out_t q_out,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sewt_pkg::rsp_t       out_data
);

  sewt_pkg::back_state_t          state_r;
  sewt_pkg::back_state_t          state_nxt;
  logic [sewt_pkg::SLOT_W-1:0]    clr_ptr_r;
  logic [sewt_pkg::SLOT_W-1:0]    clr_ptr_nxt;
  logic [sewt_pkg::IDX_W-1:0]     cur_idx_r;
  logic [sewt_pkg::IDX_W-1:0]     cur_idx_nxt;
  logic [sewt_pkg::CNT_W-1:0]     cnt_r;
  logic [sewt_pkg::CNT_W-1:0]     cnt_nxt;
  logic [sewt_pkg::CNT_W-1:0]     scan_r;
  logic [sewt_pkg::CNT_W-1:0]     scan_nxt;
  logic                           eval_v_r;
  logic                           eval_v_nxt;
  logic [sewt_pkg::IDX_W-1:0]     eval_idx_r;
  logic [sewt_pkg::IDX_W-1:0]     eval_idx_nxt;
  logic                           held_v_r;
  logic                           held_v_nxt;
  logic [sewt_pkg::IDX_W-1:0]     held_idx_r;
  logic [sewt_pkg::IDX_W-1:0]     held_idx_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  sewt_pkg::rsp_t                 out_r;
  sewt_pkg::rsp_t                 out_nxt;

  logic                           ram_we;
  logic [sewt_pkg::SLOT_W-1:0]    ram_waddr;
  logic [sewt_pkg::WORD_W-1:0]    ram_wdata;
  logic                           ram_re;
  logic [sewt_pkg::SLOT_W-1:0]    ram_raddr;
  logic [sewt_pkg::WORD_W-1:0]    ram_rdata;

  logic                           out_free;
  logic                           rd_valid;
  logic [sewt_pkg::WEIGHT_BITS-1:0] rd_weight;
  logic                           eval_go;
  logic                           scan_more;
  logic                           list_done;
  logic [sewt_pkg::IDX_W-1:0]     scan_idx;
  logic [sewt_pkg::IDX_W-1:0]     scan_lo;
  logic [sewt_pkg::IDX_W-1:0]     scan_hi;
  sewt_pkg::cmd_t                 head;

  // edge store: valid flag over the weight
  sewt_ram #(
    .WIDTH (sewt_pkg::WORD_W),
    .DEPTH (sewt_pkg::PAIR_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign head      = q_out.head;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign rd_valid  = ram_rdata[sewt_pkg::WEIGHT_BITS];
  assign rd_weight = ram_rdata[sewt_pkg::WEIGHT_BITS-1:0];
  assign clearing  = (state_r == sewt_pkg::BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // neighbour scan helpers
  assign scan_idx  = scan_r[sewt_pkg::IDX_W-1:0];
  assign scan_lo   = (scan_idx < cur_idx_r) ? scan_idx : cur_idx_r;
  assign scan_hi   = (scan_idx < cur_idx_r) ? cur_idx_r : scan_idx;
  assign scan_more = (scan_r < cnt_r);
  // evaluated entry can retire unless it must push a held hit into a busy output
  assign eval_go   = ~eval_v_r | ~rd_valid | ~held_v_r | out_free;
  assign list_done = ~scan_more & ~eval_v_r & out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sewt_pkg::BK_CLEAR: begin
        if (clr_ptr_r == sewt_pkg::SLOT_W'(sewt_pkg::PAIR_DEPTH - 1)) begin
          state_nxt = sewt_pkg::BK_IDLE;
        end
      end
      sewt_pkg::BK_IDLE: begin
        if (!q_out.empty && head.kind == sewt_pkg::CMD_CHECK) begin
          state_nxt = sewt_pkg::BK_CHECK;
        end else if (!q_out.empty && head.kind == sewt_pkg::CMD_LIST) begin
          state_nxt = sewt_pkg::BK_LIST;
        end
      end
      sewt_pkg::BK_CHECK: begin
        if (out_free) begin
          state_nxt = sewt_pkg::BK_IDLE;
        end
      end
      sewt_pkg::BK_LIST: begin
        if (list_done) begin
          state_nxt = sewt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sewt_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = head.slot;
    ram_wdata     = {1'b1, head.weight};
    ram_re        = 1'b0;
    ram_raddr     = head.slot;
    clr_ptr_nxt   = clr_ptr_r;
    cur_idx_nxt   = cur_idx_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    eval_v_nxt    = eval_v_r;
    eval_idx_nxt  = eval_idx_r;
    held_v_nxt    = held_v_r;
    held_idx_nxt  = held_idx_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;
    unique case (state_r)
      sewt_pkg::BK_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_ptr_r;
        ram_wdata   = '0;
        clr_ptr_nxt = clr_ptr_r + 1'b1;
      end
      sewt_pkg::BK_IDLE: begin
        if (!q_out.empty) begin
          unique case (head.kind)
            sewt_pkg::CMD_WRITE: begin
              ram_we = 1'b1;
              pop    = 1'b1;
            end
            sewt_pkg::CMD_CHECK: begin
              ram_re = 1'b1;
              pop    = 1'b1;
            end
            sewt_pkg::CMD_REPLY: begin
              if (out_free) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                out_nxt       = '{status: head.status, found_distance: '0,
                                  neighbor_index: '0, last: 1'b1};
              end
            end
            sewt_pkg::CMD_LIST: begin
              pop         = 1'b1;
              cur_idx_nxt = head.point;
              cnt_nxt     = head.count;
              scan_nxt    = '0;
              eval_v_nxt  = 1'b0;
              held_v_nxt  = 1'b0;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      sewt_pkg::BK_CHECK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.status         = rd_valid ? sewt_pkg::STAT_OK : sewt_pkg::STAT_NONE;
          out_nxt.found_distance = rd_valid ? sewt_pkg::DIST_W'(rd_weight) : '0;
          out_nxt.neighbor_index = '0;
          out_nxt.last           = 1'b1;
        end
      end
      sewt_pkg::BK_LIST: begin
        // retire the entry last read from the store
        if (eval_go) begin
          eval_v_nxt = 1'b0;
          if (eval_v_r && rd_valid) begin
            if (held_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: sewt_pkg::STAT_OK, found_distance: '0,
                                neighbor_index: held_idx_r, last: 1'b0};
            end
            held_v_nxt   = 1'b1;
            held_idx_nxt = eval_idx_r;
          end
          // read the next candidate, skipping the point itself
          if (scan_more) begin
            scan_nxt = scan_r + 1'b1;
            if (scan_idx != cur_idx_r) begin
              ram_re       = 1'b1;
              ram_raddr    = sewt_pkg::slot_of(scan_lo, scan_hi);
              eval_v_nxt   = 1'b1;
              eval_idx_nxt = scan_idx;
            end
          end
        end
        // close the run: last hit, or a none word for an empty listing
        if (list_done) begin
          out_valid_nxt = 1'b1;
          held_v_nxt    = 1'b0;
          if (held_v_r) begin
            out_nxt = '{status: sewt_pkg::STAT_OK, found_distance: '0,
                        neighbor_index: held_idx_r, last: 1'b1};
          end else begin
            out_nxt = '{status: sewt_pkg::STAT_NONE, found_distance: '0,
                        neighbor_index: '0, last: 1'b1};
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sewt_pkg::BK_CLEAR;
      clr_ptr_r   <= '0;
      eval_v_r    <= 1'b0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      eval_v_r    <= eval_v_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_idx_r  <= cur_idx_nxt;
    cnt_r      <= cnt_nxt;
    scan_r     <= scan_nxt;
    eval_idx_r <= eval_idx_nxt;
    held_idx_r <= held_idx_nxt;
    out_r      <= out_nxt;
  end

  // store port never read and written together
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re)) else $error("store read and write collide");
  // a held neighbour only lives inside a listing
  a_held_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> state_r == sewt_pkg::BK_LIST) else $error("stray held neighbour");
  // no command taken while the store is being cleared
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop) else $error("command taken during clearing pass");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the symmetric edge weight table. A clocked driver
// feeds add, check and neighbour listing requests from a queue filled by the
// phase sequencer; a clocked monitor predicts every reply word from its own
// copy of the edge store and point count and compares each word taken.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct {
    sewt_pkg::req_t word;
    bit             hold;
  } pend_req_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  sewt_pkg::req_t             in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  sewt_pkg::rsp_t             out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [sewt_pkg::CNT_W-1:0] cfg_data  = '0;

  // stimulus and prediction state
  pend_req_t                   pending_reqs[$];
  sewt_pkg::rsp_t              expected_words[$];
  bit                          edge_seen [sewt_pkg::PAIR_DEPTH];
  logic [sewt_pkg::DIST_W-1:0] edge_dist [sewt_pkg::PAIR_DEPTH];
  logic [sewt_pkg::CNT_W-1:0]  points_model = '0;
  logic                        words_pending = 1'b0;
  bit                          send_gaps = 1'b1;
  bit                          recv_gaps = 1'b1;
  int                          send_gap_left = 0;
  int                          recv_gap_left = 0;
  int                          idle_cycles = 0;
  int                          errors = 0;
  pend_req_t                   next_req;
  logic                        next_stall;

  symmetric_edge_weight_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // append one word to the expected reply list
  task automatic expect_word(input sewt_pkg::rsp_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  // slot of the pair (lo, hi) in the upper-triangular store, lo < hi
  function automatic int pair_slot(input int lo, input int hi);
    return lo * (2 * sewt_pkg::MAX_POINTS - lo - 1) / 2 + (hi - lo - 1);
  endfunction

  // expected reply words of one request, with the store updated for adds
  task automatic predict_table_reply(input sewt_pkg::req_t rq);
    int             live, a, b, lo, hi, s, i;
    bit             have_prev;
    sewt_pkg::rsp_t w, prev;
    live = (int'(points_model) > sewt_pkg::LIVE_MAX) ? sewt_pkg::LIVE_MAX
                                                     : int'(points_model);
    a = int'(rq.first_index);
    b = int'(rq.second_index);
    w = '0;
    w.last = 1'b1;
    have_prev = 1'b0;
    prev = '0;
    case (rq.req_type)
      sewt_pkg::REQ_ADD, sewt_pkg::REQ_CHECK: begin
        if (a >= live || b >= live) begin
          w.status = sewt_pkg::STAT_RANGE;
          expect_word(w);
        end else if (a == b) begin
          // a self-edge add is dropped, a self-pair check reads as distance zero
          if (rq.req_type == sewt_pkg::REQ_CHECK) begin
            w.status = sewt_pkg::STAT_OK;
            expect_word(w);
          end
        end else begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          s = pair_slot(lo, hi);
          if (rq.req_type == sewt_pkg::REQ_ADD) begin
            edge_seen[s] = 1'b1;
            edge_dist[s] = sewt_pkg::DIST_W'(rq.new_distance[sewt_pkg::WEIGHT_BITS-1:0]);
          end else begin
            if (edge_seen[s]) begin
              w.status = sewt_pkg::STAT_OK;
              w.found_distance = edge_dist[s];
            end else begin
              w.status = sewt_pkg::STAT_NONE;
            end
            expect_word(w);
          end
        end
      end
      sewt_pkg::REQ_LIST: begin
        if (a >= live) begin
          w.status = sewt_pkg::STAT_RANGE;
          expect_word(w);
        end else begin
          // ascending scan, held back one word so the final hit gets last
          for (i = 0; i < live; i++) begin
            if (i != a) begin
              s = (i < a) ? pair_slot(i, a) : pair_slot(a, i);
              if (edge_seen[s]) begin
                if (have_prev) expect_word(prev);
                prev = '0;
                prev.status = sewt_pkg::STAT_OK;
                prev.neighbor_index = sewt_pkg::IDX_W'(i);
                have_prev = 1'b1;
              end
            end
          end
          if (have_prev) begin
            prev.last = 1'b1;
            expect_word(prev);
          end else begin
            w.status = sewt_pkg::STAT_NONE;
            expect_word(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_reply_word(input sewt_pkg::rsp_t got);
    sewt_pkg::rsp_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected reply word status %0d index %0d",
                                got.status, got.neighbor_index));
    end else begin
      want = expected_words.pop_front();
      if (got.status != want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.found_distance != want.found_distance)
        report_mismatch($sformatf("found_distance %08h, expected %08h",
                                  got.found_distance, want.found_distance));
      if (got.neighbor_index != want.neighbor_index)
        report_mismatch($sformatf("neighbor_index %0d, expected %0d",
                                  got.neighbor_index, want.neighbor_index));
      if (got.last != want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (send_gap_left != 0) begin
        send_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].hold && (in_valid || words_pending))) begin
        next_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_data  <= next_req.word;
        send_gap_left = send_gaps ? $urandom_range(0, 3) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reply monitor, stall generation and prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      words_pending <= 1'b0;
      recv_gap_left = 0;
    end else begin
      next_stall = out_stall;
      if (out_valid && !out_stall) begin
        check_reply_word(out_data);
        recv_gap_left = recv_gaps ? $urandom_range(0, 3) : 0;
        next_stall = (recv_gap_left != 0);
      end else if (out_stall) begin
        recv_gap_left--;
        next_stall = (recv_gap_left > 0);
      end
      if (cfg_valid && cfg_ready) points_model = cfg_data;
      if (in_valid && !in_stall) predict_table_reply(in_data);
      words_pending <= (expected_words.size() != 0);
      out_stall <= next_stall;
    end
  end

  // cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_req(input logic [1:0] kind, input int a, input int b,
                           input logic [sewt_pkg::DIST_W-1:0] weight, input bit hold);
    pend_req_t p;
    p.word.req_type     = kind;
    p.word.first_index  = sewt_pkg::IDX_W'(a);
    p.word.second_index = sewt_pkg::IDX_W'(b);
    p.word.new_distance = weight;
    p.hold = hold;
    pending_reqs.insert(pending_reqs.size(), p);
  endtask

  // mostly valid points, often a few low hub points so checks and listings hit
  function automatic int pick_point(input int live);
    int m;
    m = $urandom_range(0, 9);
    if (live == 0 || m == 0) return $urandom_range(0, 63);
    if (m < 5) return $urandom_range(0, ((live < 6) ? live : 6) - 1);
    return $urandom_range(0, live - 1);
  endfunction

  task automatic queue_random(input int n, input int live);
    int                          r, k;
    logic [1:0]                  kind;
    logic [sewt_pkg::DIST_W-1:0] wt;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      kind = sewt_pkg::REQ_ADD;
      else if (r < 72) kind = sewt_pkg::REQ_CHECK;
      else if (r < 94) kind = sewt_pkg::REQ_LIST;
      else             kind = sewt_pkg::REQ_SKIP;
      r = $urandom_range(0, 7);
      if (r == 0)      wt = '0;
      else if (r == 1) wt = '1;
      else             wt = $urandom;
      queue_req(kind, pick_point(live), pick_point(live), wt, $urandom_range(0, 15) == 0);
    end
  endtask

  task automatic write_point_count(input logic [sewt_pkg::CNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // let every request go out and every reply come back, then allow for adds in flight
  task automatic wait_drained();
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid || words_pending);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic pick_idling();
    @(negedge clk);
    send_gaps = ($urandom_range(0, 3) != 0);
    recv_gaps = ($urandom_range(0, 3) != 0);
  endtask

  // phase sequencer
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty graph: everything is out of range
    write_point_count(sewt_pkg::CNT_W'(0));
    @(negedge clk);
    queue_req(sewt_pkg::REQ_CHECK, 0, 0, '0, 1'b0);
    queue_req(sewt_pkg::REQ_LIST, 0, 0, '0, 1'b0);
    queue_req(sewt_pkg::REQ_ADD, 0, 1, 32'h0001_0000, 1'b0);
    queue_req(sewt_pkg::REQ_SKIP, 63, 63, '1, 1'b0);
    wait_drained();

    // full graph, directed corners
    write_point_count(sewt_pkg::CNT_W'(64));
    @(negedge clk);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    queue_req(sewt_pkg::REQ_ADD, 0, 63, 32'hFFFF_FFFF, 1'b0);
    queue_req(sewt_pkg::REQ_ADD, 63, 62, 32'h0000_0001, 1'b0);
    queue_req(sewt_pkg::REQ_ADD, 5, 5, 32'h1234_5678, 1'b0);
    queue_req(sewt_pkg::REQ_ADD, 2, 1, 32'h0001_0000, 1'b0);
    queue_req(sewt_pkg::REQ_ADD, 1, 2, 32'h0001_8000, 1'b0);
    queue_req(sewt_pkg::REQ_CHECK, 63, 0, '0, 1'b1);
    queue_req(sewt_pkg::REQ_CHECK, 1, 2, '0, 1'b0);
    queue_req(sewt_pkg::REQ_CHECK, 7, 7, '0, 1'b0);
    queue_req(sewt_pkg::REQ_CHECK, 3, 4, '0, 1'b0);
    queue_req(sewt_pkg::REQ_LIST, 63, 0, '0, 1'b0);
    queue_req(sewt_pkg::REQ_LIST, 0, 0, '0, 1'b0);
    queue_req(sewt_pkg::REQ_LIST, 10, 0, '0, 1'b0);
    queue_req(sewt_pkg::REQ_LIST, 1, 63, '1, 1'b0);
    queue_req(sewt_pkg::REQ_ADD, 40, 41, '0, 1'b0);
    queue_req(sewt_pkg::REQ_CHECK, 41, 40, '0, 1'b0);
    queue_req(sewt_pkg::REQ_SKIP, 63, 63, '1, 1'b0);
    wait_drained();

    // count above the store size is clipped
    write_point_count(sewt_pkg::CNT_W'(127));
    pick_idling();
    queue_req(sewt_pkg::REQ_LIST, 63, 0, '0, 1'b0);
    queue_random(20, sewt_pkg::LIVE_MAX);
    wait_drained();

    // lowered count: stored edges above it are hidden
    write_point_count(sewt_pkg::CNT_W'(10));
    pick_idling();
    queue_req(sewt_pkg::REQ_CHECK, 0, 63, '0, 1'b0);
    queue_req(sewt_pkg::REQ_ADD, 63, 0, 32'h0000_0002, 1'b0);
    queue_req(sewt_pkg::REQ_LIST, 0, 0, '0, 1'b0);
    queue_random(25, 10);
    wait_drained();

    write_point_count(sewt_pkg::CNT_W'(2));
    pick_idling();
    queue_random(15, 2);
    wait_drained();

    write_point_count(sewt_pkg::CNT_W'(1));
    pick_idling();
    queue_random(10, 1);
    wait_drained();

    // back to the full graph, listings see the earlier edges again
    write_point_count(sewt_pkg::CNT_W'(64));
    pick_idling();
    queue_random(10, 64);
    queue_req(sewt_pkg::REQ_LIST, 0, 0, '0, 1'b1);
    queue_random(10, 64);
    wait_drained();

    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d reply words never arrived", expected_words.size()));
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sewt_pkg.sv
hw/rtl/sewt_ram.sv
hw/rtl/sewt_front.sv
hw/rtl/sewt_queue.sv
hw/rtl/sewt_back.sv
hw/rtl/symmetric_edge_weight_table.sv
test/tb_top.sv
